/* hw/rtl/eesc_pkg.sv */
// ----------------------------------------------------------------------------
// eesc_pkg
// shared types, constants and helpers of the effect envelope scaler
// ----------------------------------------------------------------------------
package eesc_pkg;

	localparam int NUM_W       = 40;
	localparam int DIV_W       = 16;
	localparam int ATT_CELLS   = 24;
	localparam int FOLD_STAGES = 6;
	localparam int LATENCY     = 3 + ATT_CELLS + 2 + FOLD_STAGES + 2;

	localparam logic [2:0] REG_MAGNITUDE    = 3'd0;
	localparam logic [2:0] REG_GAIN         = 3'd1;
	localparam logic [2:0] REG_ATTACK_LEVEL = 3'd2;
	localparam logic [2:0] REG_FADE_LEVEL   = 3'd3;
	localparam logic [2:0] REG_ATTACK_TIME  = 3'd4;
	localparam logic [2:0] REG_FADE_TIME    = 3'd5;
	localparam logic [2:0] REG_DURATION     = 3'd6;

	localparam logic [15:0] FULL_SCALE = 16'd255;

	typedef struct packed {
		logic [7:0]  magnitude;
		logic [7:0]  gain;
		logic [7:0]  attack_level;
		logic [7:0]  fade_level;
		logic [15:0] attack_time;
		logic [15:0] fade_time;
		logic [15:0] duration;
	} cfg_t;

	// one in-flight division: quotient bits shift into num from the bottom
	typedef struct packed {
		logic              vld;
		logic [NUM_W-1:0]  num;
		logic [DIV_W-1:0]  rem;
		logic [DIV_W-1:0]  div;
		logic              neg;
		logic [7:0]        base;
		logic signed [15:0] val;
	} work_t;

	// x / 255 for any 16-bit x whose quotient fits in 8 bits (x < 65280)
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] p;
		p = {16'd0, x} * 32'h0000_8081;
		return p[30:23];
	endfunction

endpackage

/* hw/rtl/eesc_regs.sv */
// ----------------------------------------------------------------------------
// eesc_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module eesc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output eesc_pkg::cfg_t      cfg
);

	eesc_pkg::cfg_t cfg_q;
	logic           wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magnitude    <= 8'd0;
			cfg_q.gain         <= 8'd255;
			cfg_q.attack_level <= 8'd0;
			cfg_q.fade_level   <= 8'd0;
			cfg_q.attack_time  <= 16'd0;
			cfg_q.fade_time    <= 16'd0;
			cfg_q.duration     <= 16'd0;
		end else if (wr) begin
			unique case (paddr[4:2])
				eesc_pkg::REG_MAGNITUDE:    cfg_q.magnitude    <= pwdata[7:0];
				eesc_pkg::REG_GAIN:         cfg_q.gain         <= pwdata[7:0];
				eesc_pkg::REG_ATTACK_LEVEL: cfg_q.attack_level <= pwdata[7:0];
				eesc_pkg::REG_FADE_LEVEL:   cfg_q.fade_level   <= pwdata[7:0];
				eesc_pkg::REG_ATTACK_TIME:  cfg_q.attack_time  <= pwdata[15:0];
				eesc_pkg::REG_FADE_TIME:    cfg_q.fade_time    <= pwdata[15:0];
				eesc_pkg::REG_DURATION:     cfg_q.duration     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			eesc_pkg::REG_MAGNITUDE:    prdata = {24'd0, cfg_q.magnitude};
			eesc_pkg::REG_GAIN:         prdata = {24'd0, cfg_q.gain};
			eesc_pkg::REG_ATTACK_LEVEL: prdata = {24'd0, cfg_q.attack_level};
			eesc_pkg::REG_FADE_LEVEL:   prdata = {24'd0, cfg_q.fade_level};
			eesc_pkg::REG_ATTACK_TIME:  prdata = {16'd0, cfg_q.attack_time};
			eesc_pkg::REG_FADE_TIME:    prdata = {16'd0, cfg_q.fade_time};
			eesc_pkg::REG_DURATION:     prdata = {16'd0, cfg_q.duration};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/eesc_div_cell.sv */
// ----------------------------------------------------------------------------
// eesc_div_cell
// one restoring division step, registered, passed on to the next cell
// ----------------------------------------------------------------------------
module eesc_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  eesc_pkg::work_t  din,
	output eesc_pkg::work_t  dout
);

	logic [eesc_pkg::DIV_W:0]   trial;
	logic [eesc_pkg::DIV_W:0]   diff;
	logic                       qbit;
	eesc_pkg::work_t            nxt;
	logic                       vld_q;
	eesc_pkg::work_t            data_q;

	always_comb begin
		trial = {din.rem, din.num[eesc_pkg::NUM_W-1]};
		diff  = trial - {1'b0, din.div};
		qbit  = (trial >= {1'b0, din.div});
		nxt   = din;
		nxt.num = {din.num[eesc_pkg::NUM_W-2:0], qbit};
		nxt.rem = qbit ? diff[eesc_pkg::DIV_W-1:0] : trial[eesc_pkg::DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

/* hw/rtl/effect_envelope_scaler.sv */
// ----------------------------------------------------------------------------
// effect_envelope_scaler
// attack/fade envelope applied to one force sample
// ----------------------------------------------------------------------------
// Takes one sample in every clock cycle; busy never rises. Each result
// appears with done after its start transfer has passed through
// three front stages, a chain of 24 division cells for the ramp, two
// stages for the multiply by value, six folding stages and one correction
// stage for the final /255, and one saturating output register. Results
// come out in input order and must be taken as they appear.
module effect_envelope_scaler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        elapsed_time,
	input  logic signed [15:0] value,
	output logic               done,
	output logic signed [31:0] force_res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	eesc_pkg::cfg_t cfg;

	eesc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;

	// stage 1: phase choice and gain products
	logic               in_att, in_fade;
	logic signed [16:0] dur_m_ft;
	logic [7:0]         base_lvl;
	logic signed [16:0] t_c;
	logic [15:0]        div_c;

	always_comb begin
		dur_m_ft = $signed({1'b0, cfg.duration}) - $signed({1'b0, cfg.fade_time});
		in_att   = elapsed_time < cfg.attack_time;
		in_fade  = (cfg.fade_time != 16'd0) && ($signed({1'b0, elapsed_time}) > dur_m_ft);
		priority if (in_fade) begin
			base_lvl = cfg.fade_level;
			t_c      = $signed({1'b0, cfg.duration}) - $signed({1'b0, elapsed_time});
			div_c    = cfg.fade_time;
		end else if (in_att) begin
			base_lvl = cfg.attack_level;
			t_c      = $signed({1'b0, elapsed_time});
			div_c    = cfg.attack_time;
		end else begin
			// steady: base equals magnitude so the ramp term is zero
			base_lvl = cfg.magnitude;
			t_c      = 17'sd0;
			div_c    = 16'd1;
		end
	end

	logic               vld_s1, vld_s2;
	logic [15:0]        magp_s1, basep_s1;
	logic signed [16:0] t_s1, t_s2;
	logic [15:0]        div_s1, div_s2;
	logic signed [15:0] val_s1, val_s2;
	logic [7:0]         mag_s2, base_s2;
	eesc_pkg::work_t    w_s3;
	logic               vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		magp_s1  <= {8'd0, cfg.magnitude} * {8'd0, cfg.gain};
		basep_s1 <= {8'd0, base_lvl} * {8'd0, cfg.gain};
		t_s1     <= t_c;
		div_s1   <= div_c;
		val_s1   <= value;
	end

	// stage 2: truncating /255 of the gain products
	always_ff @(posedge clk) begin
		mag_s2  <= eesc_pkg::div255(magp_s1);
		base_s2 <= eesc_pkg::div255(basep_s1);
		t_s2    <= t_s1;
		div_s2  <= div_s1;
		val_s2  <= val_s1;
	end

	// stage 3: ramp numerator, split into sign and magnitude
	logic signed [8:0]  diff_c;
	logic signed [25:0] ramp_c;
	logic [25:0]        ramp_abs;

	always_comb begin
		diff_c   = $signed({1'b0, mag_s2}) - $signed({1'b0, base_s2});
		ramp_c   = diff_c * t_s2;
		ramp_abs = ramp_c[25] ? 26'(-ramp_c) : 26'(ramp_c);
	end

	always_ff @(posedge clk) begin
		w_s3.vld  <= 1'b0;
		w_s3.num  <= {ramp_abs[23:0], 16'd0};
		w_s3.rem  <= '0;
		w_s3.div  <= div_s2;
		w_s3.neg  <= ramp_c[25];
		w_s3.base <= base_s2;
		w_s3.val  <= val_s2;
	end

	eesc_pkg::work_t att_in;
	eesc_pkg::work_t att_chain [eesc_pkg::ATT_CELLS];

	always_comb begin
		att_in     = w_s3;
		att_in.vld = vld_s3;
	end

	for (genvar i = 0; i < eesc_pkg::ATT_CELLS; i++) begin : g_att
		eesc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    ((i == 0) ? att_in : att_chain[(i == 0) ? 0 : i - 1]),
			.dout   (att_chain[i])
		);
	end

	// stage 4: level times value
	eesc_pkg::work_t    a_out;
	logic [23:0]        q1;
	logic signed [25:0] lvl_c;
	logic               vld_s4;
	logic signed [41:0] prod_s4;

	always_comb begin
		a_out = att_chain[eesc_pkg::ATT_CELLS-1];
		q1    = a_out.num[23:0];
		lvl_c = $signed({18'd0, a_out.base})
			+ (a_out.neg ? -$signed({2'b00, q1}) : $signed({2'b00, q1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= a_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= lvl_c * a_out.val;
	end

	// stage 5 on: magnitude of the product divided by 255 by folding,
	// y = 256a + b = 255a + (a + b), so a goes to the quotient and a + b stays
	logic [41:0]               prod_abs;
	logic                      fvld_q [eesc_pkg::FOLD_STAGES+1];
	logic                      fneg_q [eesc_pkg::FOLD_STAGES+1];
	logic [eesc_pkg::NUM_W-1:0] fq_q  [eesc_pkg::FOLD_STAGES+1];
	logic [eesc_pkg::NUM_W-1:0] fy_q  [eesc_pkg::FOLD_STAGES+1];

	assign prod_abs = prod_s4[41] ? 42'(-prod_s4) : 42'(prod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q[0] <= 1'b0;
		end else begin
			fvld_q[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		fq_q[0]   <= '0;
		fy_q[0]   <= prod_abs[39:0];
		fneg_q[0] <= prod_s4[41];
	end

	for (genvar k = 1; k <= eesc_pkg::FOLD_STAGES; k++) begin : g_fold
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fvld_q[k] <= 1'b0;
			end else begin
				fvld_q[k] <= fvld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			fq_q[k]   <= fq_q[k-1] + {8'd0, fy_q[k-1][eesc_pkg::NUM_W-1:8]};
			fy_q[k]   <= {8'd0, fy_q[k-1][eesc_pkg::NUM_W-1:8]} + {32'd0, fy_q[k-1][7:0]};
			fneg_q[k] <= fneg_q[k-1];
		end
	end

	// last fold leaves at most 256, one compare and increment finishes it
	logic                       quo_vld_q;
	logic                       quo_neg_q;
	logic [eesc_pkg::NUM_W-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_vld_q <= 1'b0;
		end else begin
			quo_vld_q <= fvld_q[eesc_pkg::FOLD_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		quo_q     <= fq_q[eesc_pkg::FOLD_STAGES]
			+ ((fy_q[eesc_pkg::FOLD_STAGES] >= {24'd0, eesc_pkg::FULL_SCALE}) ? 40'd1 : 40'd0);
		quo_neg_q <= fneg_q[eesc_pkg::FOLD_STAGES];
	end

	// output: sign back on, saturate to 32 bits
	logic signed [40:0] f_c;
	logic signed [31:0] sat_c;
	logic               done_q;
	logic signed [31:0] force_q;

	always_comb begin
		f_c = quo_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		priority if (f_c > 41'sd2147483647) begin
			sat_c = 32'sh7FFF_FFFF;
		end else if (f_c < -41'sd2147483648) begin
			sat_c = 32'sh8000_0000;
		end else begin
			sat_c = f_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= quo_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		force_q <= sat_c;
	end

	assign done      = done_q;
	assign force_res = force_q;

endmodule

/* hw/rtl/eesc_checker.sv */
// ----------------------------------------------------------------------------
// eesc_checker
// port-level checks of the effect envelope scaler, bound to the top level
// ----------------------------------------------------------------------------
module eesc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);

	logic acc;
	assign acc = start && !busy;

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##(eesc_pkg::LATENCY) done)
		else $error("accepted transfer gave no result");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, eesc_pkg::LATENCY))
		else $error("result without matching transfer");

endmodule

bind effect_envelope_scaler eesc_checker u_eesc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);
